/* design/indexed_sequential_list_defines.svh */
// ---------------------------------------------------------------------------
// indexed_sequential_list_defines.svh
// Assertion macros shared by the indexed list design.
// ---------------------------------------------------------------------------
`ifndef INDEXED_SEQUENTIAL_LIST_DEFINES_SVH
`define INDEXED_SEQUENTIAL_LIST_DEFINES_SVH

// Clocked check, muted while reset is applied
`define ISL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds through reset
`define ISL_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/isl_pkg.sv */
// ---------------------------------------------------------------------------
// isl_pkg
// Shared constants, codes and types of the indexed list.
// ---------------------------------------------------------------------------
package isl_pkg;

  // Default geometry
  localparam int CAPACITY_DEF     = 64;
  localparam int ELEMENT_BITS_DEF = 32;

  // Cells per registered read group
  localparam int GROUP_SIZE = 8;

  // Command codes
  localparam int CMD_W = 3;
  localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_DELETE = 3'd1;
  localparam logic [CMD_W-1:0] CMD_GET    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 3'd4;

  // Status codes
  localparam int STATUS_W = 2;
  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_RANGE     = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_WAS_EMPTY = 2'd3;

  // Per-cycle operation broadcast to every cell
  typedef struct packed {
    logic insert;  // open a slot at the position, later entries move up
    logic remove;  // close the slot at the position, later entries move down
  } cell_op_t;

  // Outcome of one command
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                rd_en;   // read value is meaningful
  } cmd_res_t;

endpackage

/* design/isl_if.sv */
// ---------------------------------------------------------------------------
// isl_if
// Valid/ready channels of the indexed list: command in, result out.
// ---------------------------------------------------------------------------
interface isl_in_if #(
  parameter int POS_W  = 7,
  parameter int ELEM_W = 32
) ();
  logic              valid;
  logic              ready;
  logic [2:0]        command;
  logic [POS_W-1:0]  position;
  logic [ELEM_W-1:0] element_value;

  modport source (output valid, command, position, element_value, input ready);
  modport sink   (input valid, command, position, element_value, output ready);
endinterface

interface isl_out_if #(
  parameter int POS_W  = 7,
  parameter int ELEM_W = 32
) ();
  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic [ELEM_W-1:0] read_value;
  logic [POS_W-1:0]  count_after;
  logic              empty_flag;

  modport source (output valid, status, read_value, count_after, empty_flag, input ready);
  modport sink   (input valid, status, read_value, count_after, empty_flag, output ready);
endinterface

/* design/indexed_sequential_list.sv */
// ---------------------------------------------------------------------------
// indexed_sequential_list
// Bounded ordered list with insert, delete and get at an index, plus clear and length query.
// ---------------------------------------------------------------------------
//  channel | role   | payload                                       | transfer
//  --------+--------+-----------------------------------------------+------------------
//  in_ch   | sink   | command, position, element_value              | valid & ready
//  out_ch  | source | status, read_value, count_after, empty_flag   | valid & ready
//
//  One command per cycle while in_ch.ready is high; the result is registered in
//  the middle stage and then in the output register. The cell chain shifts all
//  later entries on the transfer edge itself; the addressed word is gathered
//  through an OR tree of GROUP_SIZE-cell groups whose first level is registered.
//  Synchronous active-low reset empties the list; no clearing pass is needed.
//  A stalled output holds the result; input keeps flowing while the middle
//  stage can drain.
// ---------------------------------------------------------------------------
`include "indexed_sequential_list_defines.svh"

module indexed_sequential_list
  import isl_pkg::*;
#(
  parameter int CAPACITY     = CAPACITY_DEF,
  parameter int ELEMENT_BITS = ELEMENT_BITS_DEF
) (
  input logic          clk,
  input logic          rst_n,
  isl_in_if.sink       in_ch,
  isl_out_if.source    out_ch
);

  localparam int POS_W      = $clog2(CAPACITY + 1);
  localparam int NUM_GROUPS = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;
  localparam int PAD_DEPTH  = NUM_GROUPS * GROUP_SIZE;

  logic             in_fire;
  logic             s1_adv;
  cell_op_t         op;
  cmd_res_t         res;
  logic [POS_W-1:0] count_nxt;
  logic [POS_W-1:0] count_q;

  logic [ELEMENT_BITS-1:0] cell_data [CAPACITY];
  logic [ELEMENT_BITS-1:0] hit_pad   [PAD_DEPTH];
  logic [ELEMENT_BITS-1:0] grp_nxt   [NUM_GROUPS];
  logic [ELEMENT_BITS-1:0] grp_r     [NUM_GROUPS];
  logic [ELEMENT_BITS-1:0] gather;

  logic                s1_valid_r;
  logic [STATUS_W-1:0] s1_status_r;
  logic                s1_rd_en_r;
  logic [POS_W-1:0]    s1_count_r;

  logic                    out_valid_r;
  logic [STATUS_W-1:0]     out_status_r;
  logic [ELEMENT_BITS-1:0] out_read_r;
  logic [POS_W-1:0]        out_count_r;
  logic                    out_empty_r;

  // Handshake
  assign s1_adv      = s1_valid_r & (~out_valid_r | out_ch.ready);
  assign in_ch.ready = ~s1_valid_r | s1_adv;
  assign in_fire     = in_ch.valid & in_ch.ready;

  // Decode and count
  isl_ctrl #(
    .CAPACITY (CAPACITY),
    .POS_W    (POS_W)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (in_fire),
    .command   (in_ch.command),
    .position  (in_ch.position),
    .op        (op),
    .res       (res),
    .count_nxt (count_nxt),
    .count     (count_q)
  );

  // Cell chain
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [ELEMENT_BITS-1:0] prev_w;
    logic [ELEMENT_BITS-1:0] next_w;

    if (i == 0) begin : g_first
      assign prev_w = '0;
    end else begin : g_mid_prev
      assign prev_w = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign next_w = '0;
    end else begin : g_mid_next
      assign next_w = cell_data[i+1];
    end

    isl_cell #(
      .IDX    (i),
      .POS_W  (POS_W),
      .ELEM_W (ELEMENT_BITS)
    ) u_cell (
      .clk       (clk),
      .op        (op),
      .position  (in_ch.position),
      .value     (in_ch.element_value),
      .prev_data (prev_w),
      .next_data (next_w),
      .data      (cell_data[i]),
      .hit_data  (hit_pad[i])
    );
  end

  // Pad the hit words to whole groups
  for (genvar i = CAPACITY; i < PAD_DEPTH; i++) begin : g_pad
    assign hit_pad[i] = '0;
  end

  // First OR level: one word per group
  always_comb begin
    for (int g = 0; g < NUM_GROUPS; g++) begin
      grp_nxt[g] = '0;
      for (int j = 0; j < GROUP_SIZE; j++) begin
        grp_nxt[g] = grp_nxt[g] | hit_pad[g*GROUP_SIZE + j];
      end
    end
  end

  // Second OR level across groups
  always_comb begin
    gather = '0;
    for (int g = 0; g < NUM_GROUPS; g++) begin
      gather = gather | grp_r[g];
    end
  end

  // Middle stage: control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  // Middle stage: payload, taken from the pre-shift entries
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_status_r <= res.status;
      s1_rd_en_r  <= res.rd_en;
      s1_count_r  <= count_nxt;
      grp_r       <= grp_nxt;
    end
  end

  // Output register: control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output register: payload
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_status_r <= s1_status_r;
      out_read_r   <= s1_rd_en_r ? gather : '0;
      out_count_r  <= s1_count_r;
      out_empty_r  <= (s1_count_r == '0);
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.read_value  = out_read_r;
  assign out_ch.count_after = out_count_r;
  assign out_ch.empty_flag  = out_empty_r;

  // Checks
  `ISL_ASSERT(a_count_bound, count_q <= POS_W'(CAPACITY), "count above capacity")
  `ISL_ASSERT(a_clear_empties, in_fire && in_ch.command == CMD_CLEAR |=> count_q == '0,
              "clear left entries")
  `ISL_ASSERT(a_fire_fills_s1, in_fire |=> s1_valid_r, "accepted command lost")
  `ISL_ASSERT(a_empty_matches, out_valid_r |-> out_empty_r == (out_count_r == '0),
              "empty flag mismatch")
  `ISL_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !out_valid_r && !s1_valid_r,
                     "pipeline busy after reset")

endmodule

/* design/isl_cell.sv */
// ---------------------------------------------------------------------------
// isl_cell
// One list entry; loads the inserted value or takes a neighbor's word when the list shifts.
// ---------------------------------------------------------------------------
module isl_cell
  import isl_pkg::*;
#(
  parameter int IDX    = 0,
  parameter int POS_W  = 7,
  parameter int ELEM_W = 32
) (
  input  logic              clk,
  input  cell_op_t          op,
  input  logic [POS_W-1:0]  position,
  input  logic [ELEM_W-1:0] value,
  input  logic [ELEM_W-1:0] prev_data,   // entry IDX-1
  input  logic [ELEM_W-1:0] next_data,   // entry IDX+1
  output logic [ELEM_W-1:0] data,
  output logic [ELEM_W-1:0] hit_data     // own word when addressed, else zero
);

  localparam logic [POS_W-1:0] MY_POS = POS_W'(IDX);

  logic [ELEM_W-1:0] data_r;
  logic [ELEM_W-1:0] data_nxt;

  // Shift or load decision
  always_comb begin
    data_nxt = data_r;
    if (op.insert) begin
      if (position == MY_POS) begin
        data_nxt = value;
      end else if (position < MY_POS) begin
        data_nxt = prev_data;
      end
    end else if (op.remove) begin
      if (position <= MY_POS) begin
        data_nxt = next_data;
      end
    end
  end

  // Entry storage (no reset: read only after written)
  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data     = data_r;
  assign hit_data = (position == MY_POS) ? data_r : '0;

endmodule

/* design/isl_ctrl.sv */
// ---------------------------------------------------------------------------
// isl_ctrl
// Command decode, range checks and the element count.
// ---------------------------------------------------------------------------
module isl_ctrl
  import isl_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF,
  parameter int POS_W    = 7
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             fire,       // command transfer this cycle
  input  logic [CMD_W-1:0] command,
  input  logic [POS_W-1:0] position,
  output cell_op_t         op,
  output cmd_res_t         res,
  output logic [POS_W-1:0] count_nxt,  // count after this command
  output logic [POS_W-1:0] count
);

  localparam logic [POS_W-1:0] CAP = POS_W'(CAPACITY);

  logic [POS_W-1:0] count_r;
  cell_op_t         op_dec;

  // Decode against the current count
  always_comb begin
    op_dec     = '0;
    res.status = STATUS_OK;
    res.rd_en  = 1'b0;
    count_nxt  = count_r;
    unique case (command)
      CMD_INSERT: begin
        if (position > count_r) begin
          res.status = STATUS_RANGE;
        end else if (count_r == CAP) begin
          res.status = STATUS_FULL;
        end else begin
          op_dec.insert = 1'b1;
          count_nxt     = count_r + POS_W'(1);
        end
      end
      CMD_DELETE: begin
        if (position >= count_r) begin
          res.status = STATUS_RANGE;
        end else begin
          op_dec.remove = 1'b1;
          res.rd_en     = 1'b1;
          count_nxt     = count_r - POS_W'(1);
        end
      end
      CMD_GET: begin
        if (position >= count_r) begin
          res.status = STATUS_RANGE;
        end else begin
          res.rd_en = 1'b1;
        end
      end
      CMD_CLEAR: begin
        if (count_r == '0) begin
          res.status = STATUS_WAS_EMPTY;
        end else begin
          count_nxt = '0;
        end
      end
      default: begin
        // length query and unused codes: nothing changes
      end
    endcase
  end

  // Cells move only on a transfer
  assign op.insert = fire & op_dec.insert;
  assign op.remove = fire & op_dec.remove;

  // Element count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (fire) begin
      count_r <= count_nxt;
    end
  end

  assign count = count_r;

endmodule

/* dv/indexed_sequential_list_tb.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// indexed_sequential_list_tb
// Self-checking bench for the indexed list: a short table of directed
// commands, then random command streams that fill, drain and churn the list.
// Every accepted command is run through a local list model; the results coming
// out are compared in order, field by field, against it or the table's result.
// ---------------------------------------------------------------------------
module indexed_sequential_list_tb;
  import isl_pkg::*;

  localparam int POS_W    = 7;
  localparam int ELEM_W   = ELEMENT_BITS_DEF;
  localparam int LIST_CAP = CAPACITY_DEF;

  // Codes above the query act as a length query
  localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_LAST  = 3'd7;

  localparam int RANDOM_ITEMS = 1600;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_LIMIT  = 5000;
  localparam int TAIL_CYCLES  = 20;
  localparam int MAX_REPORTS  = 10;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ELEM_W-1:0]   rd;
    logic [POS_W-1:0]    cnt;
    logic                empty;
  } list_result_t;

  typedef struct {
    logic [CMD_W-1:0]  cmd;
    logic [POS_W-1:0]  pos;
    logic [ELEM_W-1:0] val;
    bit                typed;
    list_result_t      res;
  } cmd_row_t;

  typedef enum {MODE_FILL, MODE_DRAIN, MODE_MIXED, MODE_NOISE} stim_mode_e;

  logic clk;
  logic rst_n;

  isl_in_if  #(.POS_W(POS_W), .ELEM_W(ELEM_W)) in_ch ();
  isl_out_if #(.POS_W(POS_W), .ELEM_W(ELEM_W)) out_ch ();

  indexed_sequential_list dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // List model state
  logic [ELEM_W-1:0] model_words [LIST_CAP];
  int                model_len;

  list_result_t pending_results [$];
  cmd_row_t     directed_rows [$];
  int           mismatch_count = 0;
  int           cycle_count = 0;
  bit           sender_calm;

  // Clock
  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_results.size());
      $display("Verification failed");
      $finish;
    end
  end

  // Applies one command to the model list and returns its result
  function automatic list_result_t apply_list_command(logic [CMD_W-1:0] cmd,
                                                      logic [POS_W-1:0] pos,
                                                      logic [ELEM_W-1:0] val);
    list_result_t r;
    int p;
    int i;
    p        = int'(pos);
    r.status = STATUS_OK;
    r.rd     = '0;
    case (cmd)
      CMD_INSERT: begin
        if (p > model_len) begin
          r.status = STATUS_RANGE;
        end else if (model_len >= LIST_CAP) begin
          r.status = STATUS_FULL;
        end else begin
          for (i = model_len; i > p; i--) model_words[i] = model_words[i-1];
          model_words[p] = val;
          model_len++;
        end
      end
      CMD_DELETE: begin
        if (p >= model_len) begin
          r.status = STATUS_RANGE;
        end else begin
          r.rd = model_words[p];
          for (i = p; i + 1 < model_len; i++) model_words[i] = model_words[i+1];
          model_len--;
        end
      end
      CMD_GET: begin
        if (p >= model_len) r.status = STATUS_RANGE;
        else r.rd = model_words[p];
      end
      CMD_CLEAR: begin
        if (model_len == 0) r.status = STATUS_WAS_EMPTY;
        else model_len = 0;
      end
      default: ;
    endcase
    r.cnt   = POS_W'(model_len);
    r.empty = (model_len == 0);
    return r;
  endfunction

  // Idle length: mostly none or short, now and then long
  function automatic int pick_gap(bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [CMD_W-1:0] pick_command(stim_mode_e mode);
    int r;
    r = $urandom_range(0, 99);
    case (mode)
      MODE_FILL: begin
        if (r < 75) return CMD_INSERT;
        if (r < 85) return CMD_GET;
        if (r < 93) return CMD_DELETE;
        if (r < 97) return CMD_QUERY;
        if (r < 99) return CMD_W'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
        return CMD_CLEAR;
      end
      MODE_DRAIN: begin
        if (r < 55) return CMD_DELETE;
        if (r < 75) return CMD_GET;
        if (r < 88) return CMD_INSERT;
        if (r < 93) return CMD_QUERY;
        if (r < 97) return CMD_CLEAR;
        return CMD_W'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
      end
      MODE_MIXED: begin
        if (r < 35) return CMD_INSERT;
        if (r < 60) return CMD_DELETE;
        if (r < 85) return CMD_GET;
        if (r < 92) return CMD_QUERY;
        if (r < 97) return CMD_CLEAR;
        return CMD_W'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
      end
      default: return CMD_W'($urandom_range(CMD_INSERT, CMD_SPARE_LAST));
    endcase
  endfunction

  // Mostly legal indices with the ends favored, sometimes anything
  function automatic logic [POS_W-1:0] pick_position(logic [CMD_W-1:0] cmd, bit noisy);
    int top;
    int r;
    if (noisy || $urandom_range(0, 9) == 0) return POS_W'($urandom_range(0, LIST_CAP));
    if (cmd == CMD_INSERT) top = model_len;
    else if (cmd == CMD_DELETE || cmd == CMD_GET) top = model_len - 1;
    else return POS_W'($urandom_range(0, LIST_CAP));
    if (top < 0) return POS_W'($urandom_range(0, LIST_CAP));
    r = $urandom_range(0, 2);
    if (r == 0) return '0;
    if (r == 1) return POS_W'(top);
    return POS_W'($urandom_range(0, top));
  endfunction

  function automatic logic [ELEM_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return ELEM_W'($urandom);
  endfunction

  function automatic void add_row(logic [CMD_W-1:0] cmd, logic [POS_W-1:0] pos,
                                  logic [ELEM_W-1:0] val, bit typed,
                                  logic [STATUS_W-1:0] status, logic [ELEM_W-1:0] rd,
                                  logic [POS_W-1:0] cnt, logic empty);
    cmd_row_t row;
    row.cmd   = cmd;
    row.pos   = pos;
    row.val   = val;
    row.typed = typed;
    row.res   = '{status: status, rd: rd, cnt: cnt, empty: empty};
    directed_rows.push_back(row);
  endfunction

  // Offers one command and records what it should produce once transferred
  task automatic send_command(logic [CMD_W-1:0] cmd, logic [POS_W-1:0] pos,
                              logic [ELEM_W-1:0] val, bit typed, list_result_t typed_res);
    int gap;
    list_result_t pred;
    gap = pick_gap(sender_calm);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.command       <= cmd;
    in_ch.position      <= pos;
    in_ch.element_value <= val;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pred = apply_list_command(cmd, pos, val);
    pending_results.push_back(typed ? typed_res : pred);
  endtask

  // Sender holds off until every outstanding result is back
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Result receiver: random stalls with calm stretches
  initial begin
    int burst;
    int stall;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      burst = ($urandom_range(0, 3) == 0) ? 200 : $urandom_range(1, 40);
      out_ch.ready <= 1'b1;
      repeat (burst) @(posedge clk);
      stall = pick_gap(1'b0);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  // Result checker
  always @(posedge clk) begin
    list_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("unexpected result: status %0d read %h count %0d empty %0b",
                   out_ch.status, out_ch.read_value, out_ch.count_after, out_ch.empty_flag);
      end else begin
        want = pending_results.pop_front();
        if (out_ch.status !== want.status || out_ch.read_value !== want.rd ||
            out_ch.count_after !== want.cnt || out_ch.empty_flag !== want.empty) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("mismatch (exp/got): status %0d/%0d read %h/%h count %0d/%0d empty %0b/%0b",
                     want.status, out_ch.status, want.rd, out_ch.read_value,
                     want.cnt, out_ch.count_after, want.empty, out_ch.empty_flag);
        end
      end
    end
  end

  // Stimulus
  initial begin
    stim_mode_e mode;
    int block_len;
    int sent;
    int k;
    int waited;
    logic [CMD_W-1:0] cmd;
    list_result_t none;

    none           = '0;
    model_len      = 0;
    sender_calm    = 1'b0;
    rst_n               <= 1'b0;
    in_ch.valid         <= 1'b0;
    in_ch.command       <= CMD_QUERY;
    in_ch.position      <= '0;
    in_ch.element_value <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table: empty-list errors, ends of the list, spare codes, clears
    add_row(CMD_QUERY,       7'd0,  32'h0,        1, STATUS_OK,        32'h0,        7'd0, 1);
    add_row(CMD_CLEAR,       7'd0,  32'h0,        1, STATUS_WAS_EMPTY, 32'h0,        7'd0, 1);
    add_row(CMD_GET,         7'd0,  32'h0,        1, STATUS_RANGE,     32'h0,        7'd0, 1);
    add_row(CMD_DELETE,      7'd64, 32'h0,        1, STATUS_RANGE,     32'h0,        7'd0, 1);
    add_row(CMD_INSERT,      7'd1,  32'h1234,     1, STATUS_RANGE,     32'h0,        7'd0, 1);
    add_row(CMD_INSERT,      7'd64, 32'h1,        1, STATUS_RANGE,     32'h0,        7'd0, 1);
    add_row(CMD_INSERT,      7'd0,  32'hFFFFFFFF, 1, STATUS_OK,        32'h0,        7'd1, 0);
    add_row(CMD_GET,         7'd0,  32'h0,        1, STATUS_OK,        32'hFFFFFFFF, 7'd1, 0);
    add_row(CMD_INSERT,      7'd0,  32'h0,        1, STATUS_OK,        32'h0,        7'd2, 0);
    add_row(CMD_INSERT,      7'd2,  32'hA5A5A5A5, 1, STATUS_OK,        32'h0,        7'd3, 0);
    add_row(CMD_INSERT,      7'd1,  32'h5A5A5A5A, 0, STATUS_OK,        32'h0,        7'd0, 0);
    add_row(CMD_GET,         7'd3,  32'h0,        1, STATUS_OK,        32'hA5A5A5A5, 7'd4, 0);
    add_row(CMD_GET,         7'd4,  32'h0,        1, STATUS_RANGE,     32'h0,        7'd4, 0);
    add_row(CMD_DELETE,      7'd1,  32'h0,        1, STATUS_OK,        32'h5A5A5A5A, 7'd3, 0);
    add_row(CMD_DELETE,      7'd2,  32'h0,        1, STATUS_OK,        32'hA5A5A5A5, 7'd2, 0);
    add_row(CMD_SPARE_FIRST, 7'd0,  32'h0,        0, STATUS_OK,        32'h0,        7'd0, 0);
    add_row(CMD_SPARE_LAST,  7'd64, 32'hFFFF,     0, STATUS_OK,        32'h0,        7'd0, 0);
    add_row(CMD_GET,         7'd1,  32'h0,        1, STATUS_OK,        32'hFFFFFFFF, 7'd2, 0);
    add_row(CMD_DELETE,      7'd0,  32'h0,        1, STATUS_OK,        32'h0,        7'd1, 0);
    add_row(CMD_CLEAR,       7'd0,  32'h0,        1, STATUS_OK,        32'h0,        7'd0, 1);
    add_row(CMD_CLEAR,       7'd0,  32'h0,        1, STATUS_WAS_EMPTY, 32'h0,        7'd0, 1);
    add_row(CMD_INSERT,      7'd0,  32'h80000001, 1, STATUS_OK,        32'h0,        7'd1, 0);
    add_row(CMD_DELETE,      7'd0,  32'h0,        1, STATUS_OK,        32'h80000001, 7'd0, 1);

    foreach (directed_rows[i])
      send_command(directed_rows[i].cmd, directed_rows[i].pos, directed_rows[i].val,
                   directed_rows[i].typed, directed_rows[i].res);
    wait_drained();

    // Random blocks; the first one is a 120-command fill block
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if (sent == 0) begin
        mode      = MODE_FILL;
        block_len = 120;
      end else begin
        mode      = stim_mode_e'($urandom_range(MODE_FILL, MODE_NOISE));
        block_len = $urandom_range(40, 140);
      end
      sender_calm = ($urandom_range(0, 3) == 0);
      for (k = 0; k < block_len; k++) begin
        cmd = pick_command(mode);
        send_command(cmd, pick_position(cmd, mode == MODE_NOISE), pick_value(), 0, none);
      end
      sent += block_len;
      if ($urandom_range(0, 5) == 0) wait_drained();
    end
    in_ch.valid <= 1'b0;

    // Let the last results come back, then a short tail
    waited = 0;
    while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_results.size() != 0)
      $display("%0d results never arrived", pending_results.size());
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+design
design/isl_pkg.sv
design/isl_if.sv
design/isl_cell.sv
design/isl_ctrl.sv
design/indexed_sequential_list.sv
dv/indexed_sequential_list_tb.sv
